/* src/hcg_pkg.sv */
// hcg_pkg: types, widths and constants shared by the hand curl grip detector.
// Used by hcg_alu, hcg_grip and hand_curl_grip_detector; depends on nothing.
package hcg_pkg;

   localparam int COORD_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF  = 12;

   localparam int AW       = 64;   // shared unit operand width
   localparam int SQ_IN_W  = 30;   // magnitudes are squared at this width
   localparam int SUM_W    = 62;   // sum of three 60-bit squares
   localparam int SH_W     = 2;    // normalizing shift, at most 2 for 32-bit coords
   localparam int GRIP_W   = 13;   // Q12 grip values and thresholds
   localparam int CSUM_W   = 15;
   localparam int CNT_W    = 3;
   localparam int GST_W    = 2;
   localparam int RSP_W    = 24;   // 18 payload bits padded to whole bytes
   localparam int Q12_FRAC = 12;

   localparam logic [GRIP_W-1:0] GRIP_THR_RST = 13'd2458;
   localparam logic [GRIP_W-1:0] REL_THR_RST  = 13'd1638;
   localparam logic [GRIP_W:0]   STEP_FIFTH   = 14'd819;
   localparam logic [GRIP_W:0]   STEP_TENTH   = 14'd410;
   localparam logic [CNT_W-1:0]  CNT_MAX      = 3'd7;

   typedef enum logic {
      CSR_GRIP_THR = 1'b0,
      CSR_REL_THR  = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ALU_SUB,
      ALU_ABSDIFF,
      ALU_MUL
   } alu_op_type;

   typedef struct packed {
      alu_op_type      op;
      logic [AW-1:0]   a;
      logic [AW-1:0]   b;
   } alu_req_type;

   typedef struct packed {
      logic [AW-1:0]   res;
      logic            ge;
   } alu_rsp_type;

   typedef enum logic [GST_W-1:0] {
      GS_OPEN     = 2'd0,
      GS_GRIPPING = 2'd1,
      GS_CLOSED   = 2'd2
   } grip_state_type;

   typedef struct packed {
      logic              update;
      logic [GRIP_W-1:0] value;
      logic [GRIP_W-1:0] grip_thr;
      logic [GRIP_W-1:0] rel_thr;
   } grip_upd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SHIFT,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_SQRT,
      ST_CURL,
      ST_DIV3,
      ST_ACC,
      ST_AVG,
      ST_GRIP
   } seq_state_type;

endpackage

/* src/hcg_alu.sv */
// hcg_alu: the shared arithmetic unit: subtract/compare, absolute difference
// and a 30x30 multiply. Depends on hcg_pkg.
module hcg_alu (
   input  hcg_pkg::alu_req_type req,
   output hcg_pkg::alu_rsp_type rsp
);

   logic [hcg_pkg::AW-1:0]          diff;
   logic [2*hcg_pkg::SQ_IN_W-1:0]   prod;

   always_comb begin
      diff = req.a - req.b;
      prod = req.a[hcg_pkg::SQ_IN_W-1:0] * req.b[hcg_pkg::SQ_IN_W-1:0];
      rsp.ge  = (req.a >= req.b);
      rsp.res = diff;
      unique case (req.op)
         hcg_pkg::ALU_SUB: begin
            rsp.res = diff;
         end
         hcg_pkg::ALU_ABSDIFF: begin
            // operands are sign-extended coordinates, so no overflow here
            rsp.res = diff[hcg_pkg::AW-1] ? (hcg_pkg::AW'(0) - diff) : diff;
         end
         hcg_pkg::ALU_MUL: begin
            rsp.res = hcg_pkg::AW'(prod);
         end
         default: begin
            rsp.res = diff;
         end
      endcase
   end

endmodule

/* src/hcg_grip.sv */
// hcg_grip: open / gripping / closed state with hysteresis, updated once per
// frame. Depends on hcg_pkg.
module hcg_grip (
   input  logic                          clock,
   input  logic                          reset,
   input  hcg_pkg::grip_upd_type         upd,
   output logic [hcg_pkg::GST_W-1:0]     next_state
);

   hcg_pkg::grip_state_type hand_state_ff, hand_state_in, st;
   logic [hcg_pkg::GRIP_W:0] v, g, r;

   always_comb begin
      v = {1'b0, upd.value};
      g = {1'b0, upd.grip_thr};
      r = {1'b0, upd.rel_thr};
      unique case (hand_state_ff)
         hcg_pkg::GS_GRIPPING: begin
            if (v >= g + hcg_pkg::STEP_FIFTH)
               st = hcg_pkg::GS_CLOSED;
            else if (v + hcg_pkg::STEP_TENTH < g)
               st = hcg_pkg::GS_OPEN;
            else
               st = hcg_pkg::GS_GRIPPING;
         end
         hcg_pkg::GS_CLOSED: begin
            st = (v < r) ? hcg_pkg::GS_GRIPPING : hcg_pkg::GS_CLOSED;
         end
         default: begin
            st = (v >= g) ? hcg_pkg::GS_GRIPPING : hcg_pkg::GS_OPEN;
         end
      endcase
      // deep drop below the threshold skips straight back to open
      if (st == hcg_pkg::GS_GRIPPING && v + hcg_pkg::STEP_FIFTH < g)
         st = hcg_pkg::GS_OPEN;
      hand_state_in = upd.update ? st : hand_state_ff;
      next_state    = st;
   end

   always_ff @(posedge clock) begin
      if (reset)
         hand_state_ff <= hcg_pkg::GS_OPEN;
      else
         hand_state_ff <= hand_state_in;
   end

endmodule

/* src/hand_curl_grip_detector.sv */
// hand_curl_grip_detector: top level, sequencer and datapath registers.
// Depends on hcg_pkg, hcg_alu and hcg_grip.
//
// Usage: one req transaction per finger carries wrist, base and tip
// positions; req_tlast marks the last finger of a frame. Only that finger
// yields one rsp transaction: average curl, grip state and valid finger count.
// Each finger is worked through one shared subtract/multiply unit:
// 6 difference steps, 7 multiply steps, 2*FRAC_BITS divide steps,
// FRAC_BITS square root steps and FRAC_BITS+3 divide-by-three steps.
// A full finger runs through all of these steps from acceptance to the next
// req_tready; invalid or fully open fingers leave early. The last finger
// adds the average divide and the state update.
// req_tready is high only while no finger is being worked on.
// Results sit in an output register; the next finger is accepted while a
// result waits. A stalled rsp side blocks only the next frame's result step.
// Reset clears the accumulators, the grip state (open) and restores the
// threshold registers to their defaults. csr writes take effect in the cycle after csr_we.
module hand_curl_grip_detector #(
   parameter int COORD_BITS = hcg_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = hcg_pkg::FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // wrist_x, wrist_y, wrist_z, base_x, base_y, base_z, tip_x, tip_y, tip_z
   input  logic [((9*COORD_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                  req_tlast,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // grip_value[12:0], grip_state[14:13], valid_fingers[17:15], zero pad
   output logic [hcg_pkg::RSP_W-1:0]             rsp_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [hcg_pkg::GRIP_W-1:0]            csr_wdata
);

   localparam int CW     = COORD_BITS;
   localparam int Q_W    = 2*FRAC_BITS;
   localparam int N_W    = FRAC_BITS + 3;
   localparam int STEP_W = $clog2(2*FRAC_BITS + 1);
   localparam int SHR    = (FRAC_BITS >= hcg_pkg::Q12_FRAC) ? FRAC_BITS - hcg_pkg::Q12_FRAC : 0;
   localparam int SHL    = (FRAC_BITS <  hcg_pkg::Q12_FRAC) ? hcg_pkg::Q12_FRAC - FRAC_BITS : 0;
   localparam int AW     = hcg_pkg::AW;

   hcg_pkg::seq_state_type state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;

   logic signed [CW-1:0] wrist_ff[3], base_ff[3], tip_ff[3];
   logic signed [CW-1:0] wrist_in[3], base_in[3], tip_in[3];
   logic [CW-1:0]        dm_ff[6], dm_in[6];
   logic                 last_ff, last_in, bad_ff, bad_in, fv_ff, fv_in;
   logic [hcg_pkg::SH_W-1:0]       sh_ff, sh_in;
   logic [2*hcg_pkg::SQ_IN_W-1:0]  prod_ff, prod_in;
   logic [hcg_pkg::SUM_W-1:0]      st_ff, st_in, ss_ff, ss_in;
   logic [AW-1:0]                  rem_ff, rem_in;
   logic [Q_W-1:0]                 quo_ff, quo_in, res_ff, res_in, sqbit_ff, sqbit_in;
   logic [N_W-1:0]                 n_ff, n_in;
   logic [hcg_pkg::GRIP_W-1:0]     curl_ff, curl_in;
   logic [hcg_pkg::CSUM_W-1:0]     sum_ff, sum_in;
   logic [hcg_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic [hcg_pkg::GRIP_W-1:0]     grip_thr_ff, grip_thr_in, rel_thr_ff, rel_thr_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hcg_pkg::RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   hcg_pkg::alu_req_type   alu_req;
   hcg_pkg::alu_rsp_type   alu_rsp;
   hcg_pkg::grip_upd_type  grip_upd;
   logic [hcg_pkg::GST_W-1:0] grip_next;

   logic [2:0]           k;
   logic [1:0]           idx;
   logic [CW-1:0]        orv, dm_sel;
   logic [AW-1:0]        t;
   logic [Q_W-1:0]       qf, trial, cl;
   logic [N_W-1:0]       five_r, four_one;
   logic [hcg_pkg::GRIP_W-1:0] avg;
   logic                 grip_load;

   hcg_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   hcg_grip u_grip (
      .clock      (clock),
      .reset      (reset),
      .upd        (grip_upd),
      .next_state (grip_next)
   );

   assign req_tready = (state_ff == hcg_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes
   always_comb begin
      grip_thr_in = grip_thr_ff;
      rel_thr_in  = rel_thr_ff;
      if (csr_we) begin
         unique case (hcg_pkg::csr_index_type'(csr_index))
            hcg_pkg::CSR_GRIP_THR: grip_thr_in = csr_wdata;
            hcg_pkg::CSR_REL_THR:  rel_thr_in  = csr_wdata;
            default:               grip_thr_in = grip_thr_ff;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      wrist_in = wrist_ff;
      base_in  = base_ff;
      tip_in   = tip_ff;
      dm_in    = dm_ff;
      last_in  = last_ff;
      bad_in   = bad_ff;
      fv_in    = fv_ff;
      sh_in    = sh_ff;
      prod_in  = prod_ff;
      st_in    = st_ff;
      ss_in    = ss_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      sqbit_in = sqbit_ff;
      n_in     = n_ff;
      curl_in  = curl_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      grip_load = 1'b0;

      alu_req.op = hcg_pkg::ALU_SUB;
      alu_req.a  = '0;
      alu_req.b  = '0;

      k      = step_ff[2:0];
      idx    = (k < 3'd3) ? k[1:0] : 2'(k - 3'd3);
      orv    = '0;
      dm_sel = (k < 3'd6) ? dm_ff[k] : '0;
      t      = '0;
      qf     = {quo_ff[Q_W-2:0], alu_rsp.ge};
      trial  = res_ff + sqbit_ff;
      cl     = '0;
      five_r = (N_W'(res_ff[FRAC_BITS-1:0]) << 2) + N_W'(res_ff[FRAC_BITS-1:0]);
      four_one = N_W'(4) << FRAC_BITS;
      avg    = (cnt_ff == '0) ? '0 : quo_ff[hcg_pkg::GRIP_W-1:0];

      grip_upd.update   = 1'b0;
      grip_upd.value    = avg;
      grip_upd.grip_thr = grip_thr_ff;
      grip_upd.rel_thr  = rel_thr_ff;

      unique case (state_ff)
         hcg_pkg::ST_IDLE: begin
            for (int i = 0; i < 3; i++) begin
               wrist_in[i] = req_tdata[i*CW +: CW];
               base_in[i]  = req_tdata[(3+i)*CW +: CW];
               tip_in[i]   = req_tdata[(6+i)*CW +: CW];
            end
            last_in = req_tlast;
            bad_in  = (req_tdata[3*CW +: 3*CW] == '0) || (req_tdata[6*CW +: 3*CW] == '0);
            if (req_tvalid) begin
               step_in  = '0;
               st_in    = '0;
               ss_in    = '0;
               state_in = hcg_pkg::ST_DIFF;
            end
         end
         hcg_pkg::ST_DIFF: begin
            // tip-base for steps 0..2, base-wrist for steps 3..5
            alu_req.op = hcg_pkg::ALU_ABSDIFF;
            if (k < 3'd3) begin
               alu_req.a = AW'(tip_ff[idx]);
               alu_req.b = AW'(base_ff[idx]);
            end else begin
               alu_req.a = AW'(base_ff[idx]);
               alu_req.b = AW'(wrist_ff[idx]);
            end
            dm_in[k] = alu_rsp.res[CW-1:0];
            step_in  = step_ff + 1'b1;
            if (k == 3'd5) begin
               step_in  = '0;
               state_in = hcg_pkg::ST_SHIFT;
            end
         end
         hcg_pkg::ST_SHIFT: begin
            for (int i = 0; i < 6; i++)
               orv = orv | dm_ff[i];
            sh_in = '0;
            for (int i = 0; i < CW; i++)
               if (orv[i] && i >= hcg_pkg::SQ_IN_W)
                  sh_in = hcg_pkg::SH_W'(i - hcg_pkg::SQ_IN_W + 1);
            state_in = hcg_pkg::ST_MUL;
         end
         hcg_pkg::ST_MUL: begin
            // product of step k is registered and added in step k+1
            alu_req.op = hcg_pkg::ALU_MUL;
            alu_req.a  = AW'(hcg_pkg::SQ_IN_W'(dm_sel >> sh_ff));
            alu_req.b  = AW'(hcg_pkg::SQ_IN_W'(dm_sel >> sh_ff));
            prod_in    = alu_rsp.res[2*hcg_pkg::SQ_IN_W-1:0];
            if (k != 3'd0) begin
               if (k <= 3'd3)
                  st_in = st_ff + hcg_pkg::SUM_W'(prod_ff);
               else
                  ss_in = ss_ff + hcg_pkg::SUM_W'(prod_ff);
            end
            step_in = step_ff + 1'b1;
            if (k == 3'd6) begin
               step_in  = '0;
               state_in = hcg_pkg::ST_CHECK;
            end
         end
         hcg_pkg::ST_CHECK: begin
            alu_req.a = AW'(st_ff);
            alu_req.b = AW'(ss_ff);
            if (bad_ff || ss_ff == '0) begin
               fv_in    = 1'b0;
               state_in = hcg_pkg::ST_ACC;
            end else if (alu_rsp.ge) begin
               fv_in    = 1'b1;
               curl_in  = '0;
               state_in = hcg_pkg::ST_ACC;
            end else begin
               rem_in   = AW'(st_ff);
               quo_in   = '0;
               step_in  = '0;
               state_in = hcg_pkg::ST_DIV;
            end
         end
         hcg_pkg::ST_DIV: begin
            t         = rem_ff << 1;
            alu_req.a = t;
            alu_req.b = AW'(ss_ff);
            rem_in    = alu_rsp.ge ? alu_rsp.res : t;
            quo_in    = qf;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(Q_W-1)) begin
               rem_in   = AW'(qf);
               res_in   = '0;
               sqbit_in = Q_W'(1) << (Q_W-2);
               step_in  = '0;
               state_in = hcg_pkg::ST_SQRT;
            end
         end
         hcg_pkg::ST_SQRT: begin
            alu_req.a = rem_ff;
            alu_req.b = AW'(trial);
            if (alu_rsp.ge) begin
               rem_in = alu_rsp.res;
               res_in = (res_ff >> 1) + sqbit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            sqbit_in = sqbit_ff >> 2;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(FRAC_BITS-1)) begin
               step_in  = '0;
               state_in = hcg_pkg::ST_CURL;
            end
         end
         hcg_pkg::ST_CURL: begin
            alu_req.a = AW'(four_one);
            alu_req.b = AW'(five_r);
            fv_in     = 1'b1;
            if (!alu_rsp.ge || alu_rsp.res == '0) begin
               curl_in  = '0;
               state_in = hcg_pkg::ST_ACC;
            end else begin
               n_in     = alu_rsp.res[N_W-1:0];
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = hcg_pkg::ST_DIV3;
            end
         end
         hcg_pkg::ST_DIV3: begin
            t         = (rem_ff << 1) | AW'(n_ff[N_W-1]);
            alu_req.a = t;
            alu_req.b = AW'(3);
            rem_in    = alu_rsp.ge ? alu_rsp.res : t;
            quo_in    = qf;
            n_in      = n_ff << 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(N_W-1)) begin
               cl       = (qf > (Q_W'(1) << FRAC_BITS)) ? (Q_W'(1) << FRAC_BITS) : qf;
               curl_in  = hcg_pkg::GRIP_W'((cl >> SHR) << SHL);
               step_in  = '0;
               state_in = hcg_pkg::ST_ACC;
            end
         end
         hcg_pkg::ST_ACC: begin
            if (fv_ff && cnt_ff < hcg_pkg::CNT_MAX) begin
               sum_in = sum_ff + hcg_pkg::CSUM_W'(curl_ff);
               cnt_in = cnt_ff + 1'b1;
            end
            if (last_ff) begin
               rem_in   = '0;
               quo_in   = '0;
               step_in  = '0;
               state_in = hcg_pkg::ST_AVG;
            end else begin
               state_in = hcg_pkg::ST_IDLE;
            end
         end
         hcg_pkg::ST_AVG: begin
            // sum shifts out msb first; it is cleared at the end of the frame anyway
            t         = (rem_ff << 1) | AW'(sum_ff[hcg_pkg::CSUM_W-1]);
            alu_req.a = t;
            alu_req.b = AW'(cnt_ff);
            rem_in    = alu_rsp.ge ? alu_rsp.res : t;
            quo_in    = qf;
            sum_in    = sum_ff << 1;
            step_in   = step_ff + 1'b1;
            if (step_ff == STEP_W'(hcg_pkg::CSUM_W-1)) begin
               step_in  = '0;
               state_in = hcg_pkg::ST_GRIP;
            end
         end
         hcg_pkg::ST_GRIP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               grip_load       = 1'b1;
               grip_upd.update = 1'b1;
               rsp_valid_in    = 1'b1;
               rsp_data_in     = hcg_pkg::RSP_W'({cnt_ff, grip_next, avg});
               sum_in          = '0;
               cnt_in          = '0;
               state_in        = hcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hcg_pkg::ST_IDLE;
         step_ff      <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         grip_thr_ff  <= hcg_pkg::GRIP_THR_RST;
         rel_thr_ff   <= hcg_pkg::REL_THR_RST;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         grip_thr_ff  <= grip_thr_in;
         rel_thr_ff   <= rel_thr_in;
      end
   end

   always_ff @(posedge clock) begin
      wrist_ff    <= wrist_in;
      base_ff     <= base_in;
      tip_ff      <= tip_in;
      dm_ff       <= dm_in;
      last_ff     <= last_in;
      bad_ff      <= bad_in;
      fv_ff       <= fv_in;
      sh_ff       <= sh_in;
      prod_ff     <= prod_in;
      st_ff       <= st_in;
      ss_ff       <= ss_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      res_ff      <= res_in;
      sqbit_ff    <= sqbit_in;
      n_ff        <= n_in;
      curl_ff     <= curl_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("finger accepted while another is in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");

   a_grip_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[hcg_pkg::GRIP_W-1:0] <= 13'd4096))
      else $error("grip value above one");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      grip_load |=> (cnt_ff == '0 && sum_ff == '0))
      else $error("accumulators not cleared after frame");

endmodule
